// ----- rtl/core/sdsp_pkg.sv -----
`timescale 1ns / 1ps
package sdsp_pkg;

    // input function codes
    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_STEP   = 2'd1,
        FUNC_ENC    = 2'd2,
        FUNC_UNUSED = 2'd3
    } func_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_PROP_GAIN  = 2'd0,
        CFG_INTEG_GAIN = 2'd1,
        CFG_DERIV_GAIN = 2'd2,
        CFG_CUR_LIMIT  = 2'd3
    } cfg_idx_t;

    localparam int ERR_W    = 16;
    localparam int GAIN_W   = 8;
    localparam int SENSE_W  = 13;
    localparam int RED_W    = 12;
    localparam int DUTY_W   = 12;
    localparam int MAG_SHIFT = 4;
    localparam logic [DUTY_W-1:0] DUTY_MAX = 12'd4095;
    localparam logic [DUTY_W-1:0] DUTY_MIN = 12'd1;
    localparam int QDEPTH   = 2;

    // loop gains handed to the back end
    typedef struct packed {
        logic [GAIN_W-1:0] prop;
        logic [GAIN_W-1:0] integ;
        logic [GAIN_W-1:0] deriv;
    } gains_t;

endpackage

// ----- rtl/core/sdsp_front.sv -----
`timescale 1ns / 1ps
module sdsp_front
    import sdsp_pkg::*;
#(
    parameter int INTEGRAL_LIMIT = 4000,
    parameter int REDUCE_LIMIT   = 4094,
    parameter int STEP_SCALE     = 1,
    parameter int INTEG_W        = 13
)(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      q_full,
    input  logic [1:0]                func,
    input  logic                      direction,
    input  logic [SENSE_W-1:0]        sense_millivolts,
    input  logic [GAIN_W-1:0]         cur_setting,
    output logic                      push,
    output logic signed [ERR_W-1:0]   tick_err,
    output logic signed [ERR_W-1:0]   tick_deriv,
    output logic signed [INTEG_W-1:0] tick_integ,
    output logic [RED_W-1:0]          tick_red
);

    localparam int ISUM_W = ((INTEG_W > ERR_W) ? INTEG_W : ERR_W) + 1;
    localparam logic signed [ISUM_W-1:0] IPOS = ISUM_W'(INTEGRAL_LIMIT);
    localparam logic signed [ISUM_W-1:0] INEG = -IPOS;
    localparam logic signed [15:0] RMAX = 16'(REDUCE_LIMIT);
    localparam logic [ERR_W-1:0] STEP_D = ERR_W'(STEP_SCALE);

    logic signed [ERR_W-1:0]   err_count_reg, err_count_next;
    logic signed [ERR_W-1:0]   err_prev_reg, err_prev_next;
    logic signed [INTEG_W-1:0] integ_reg, integ_next;
    logic [RED_W-1:0]          red_reg, red_next;

    logic                      accept;
    logic signed [ISUM_W-1:0]  isum;
    logic signed [15:0]        rsum;
    logic signed [INTEG_W-1:0] integ_clamped;
    logic [RED_W-1:0]          red_clamped;

    assign accept = in_valid && !q_full;

    assign isum = ISUM_W'(integ_reg) + ISUM_W'(err_count_reg);
    assign rsum = $signed({4'b0, red_reg}) + $signed({3'b0, sense_millivolts})
                - $signed({5'b0, cur_setting, 3'b0});

    always_comb
    begin
        if (isum > IPOS)
            integ_clamped = INTEG_W'(IPOS);
        else if (isum < INEG)
            integ_clamped = INTEG_W'(INEG);
        else
            integ_clamped = INTEG_W'(isum);

        if (rsum < 16'sd0)
            red_clamped = '0;
        else if (rsum > RMAX)
            red_clamped = RED_W'(RMAX);
        else
            red_clamped = RED_W'(rsum);
    end

    always_comb
    begin
        err_count_next = err_count_reg;
        err_prev_next  = err_prev_reg;
        integ_next     = integ_reg;
        red_next       = red_reg;
        push           = 1'b0;
        if (accept)
        begin
            case (func_t'(func))
                FUNC_STEP:
                begin
                    err_count_next = direction ? err_count_reg + STEP_D
                                               : err_count_reg - STEP_D;
                    err_prev_next  = direction ? err_prev_reg + STEP_D
                                               : err_prev_reg - STEP_D;
                end
                FUNC_ENC:
                begin
                    err_count_next = direction ? err_count_reg + 16'sd1
                                               : err_count_reg - 16'sd1;
                end
                FUNC_TICK:
                begin
                    err_prev_next = err_count_reg;
                    integ_next    = integ_clamped;
                    red_next      = red_clamped;
                    push          = 1'b1;
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    assign tick_err   = err_count_reg;
    assign tick_deriv = err_prev_reg - err_count_reg;
    assign tick_integ = integ_clamped;
    assign tick_red   = red_clamped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_count_reg <= '0;
            err_prev_reg  <= '0;
            integ_reg     <= '0;
            red_reg       <= '0;
        end
        else
        begin
            err_count_reg <= err_count_next;
            err_prev_reg  <= err_prev_next;
            integ_reg     <= integ_next;
            red_reg       <= red_next;
        end
    end

endmodule

// ----- rtl/core/sdsp_queue.sv -----
`timescale 1ns / 1ps
module sdsp_queue
    import sdsp_pkg::*;
#(
    parameter int WIDTH = 57
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             full,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    logic [WIDTH-1:0] slot_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign do_pop    = pop && not_empty;
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/core/sdsp_back.sv -----
`timescale 1ns / 1ps
module sdsp_back
    import sdsp_pkg::*;
#(
    parameter int INTEG_W = 13
)(
    input  logic                      clk,
    input  logic                      rst_n,
    input  gains_t                    gains,
    input  logic                      q_not_empty,
    input  logic signed [ERR_W-1:0]   q_err,
    input  logic signed [ERR_W-1:0]   q_deriv,
    input  logic signed [INTEG_W-1:0] q_integ,
    input  logic [RED_W-1:0]          q_red,
    output logic                      q_pop,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      phase,
    output logic [DUTY_W-1:0]         duty,
    output logic signed [ERR_W-1:0]   position_error
);

    localparam int EPROD_W = ERR_W + GAIN_W + 1;
    localparam int IPROD_W = INTEG_W + GAIN_W + 1;
    localparam int SUM_W   = ((IPROD_W > EPROD_W) ? IPROD_W : EPROD_W) + 2;

    // stage 1: products
    logic                      s1_valid_reg;
    logic signed [EPROD_W-1:0] p_prod_reg, d_prod_reg;
    logic signed [IPROD_W-1:0] i_prod_reg;
    logic signed [ERR_W-1:0]   s1_err_reg;
    logic [RED_W-1:0]          s1_red_reg;

    // stage 2: controller sum
    logic                      s2_valid_reg;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic signed [ERR_W-1:0]   s2_err_reg;
    logic [RED_W-1:0]          s2_red_reg;

    // output register
    logic                      out_valid_reg;
    logic                      phase_reg, phase_next;
    logic [DUTY_W-1:0]         duty_reg, duty_next;
    logic signed [ERR_W-1:0]   out_err_reg;

    logic                      out_adv, s2_load, s1_load;
    logic [SUM_W-1:0]          mag;
    logic [SUM_W-1:0]          mag_sh;
    logic [DUTY_W-1:0]         mag_cap;
    logic signed [DUTY_W:0]    diff;

    assign out_adv = !out_valid_reg || !out_stall;
    assign s2_load = !s2_valid_reg || out_adv;
    assign s1_load = !s1_valid_reg || s2_load;
    assign q_pop   = s1_load && q_not_empty;

    assign sum_next = SUM_W'(p_prod_reg) + SUM_W'(i_prod_reg) - SUM_W'(d_prod_reg);

    always_comb
    begin
        phase_next = !sum_reg[SUM_W-1];
        mag        = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        mag_sh     = mag >> MAG_SHIFT;
        if (|mag_sh[SUM_W-1:DUTY_W])
            mag_cap = DUTY_MAX;
        else
            mag_cap = mag_sh[DUTY_W-1:0];
        diff = $signed({1'b0, mag_cap}) - $signed({1'b0, s2_red_reg});
        if (diff < $signed({1'b0, DUTY_MIN}))
            duty_next = DUTY_MIN;
        else
            duty_next = diff[DUTY_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            p_prod_reg <= $signed({1'b0, gains.prop}) * q_err;
            i_prod_reg <= $signed({1'b0, gains.integ}) * q_integ;
            d_prod_reg <= $signed({1'b0, gains.deriv}) * q_deriv;
            s1_err_reg <= q_err;
            s1_red_reg <= q_red;
        end
        if (s2_load && s1_valid_reg)
        begin
            sum_reg    <= sum_next;
            s2_err_reg <= s1_err_reg;
            s2_red_reg <= s1_red_reg;
        end
        if (out_adv && s2_valid_reg)
        begin
            phase_reg   <= phase_next;
            duty_reg    <= duty_next;
            out_err_reg <= s2_err_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
                s1_valid_reg <= q_not_empty;
            if (s2_load)
                s2_valid_reg <= s1_valid_reg;
            if (out_adv)
                out_valid_reg <= s2_valid_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign phase          = phase_reg;
    assign duty           = duty_reg;
    assign position_error = out_err_reg;

endmodule

// ----- rtl/core/step_dir_servo_pid_current_limit_top.sv -----
`timescale 1ns / 1ps
// channel | signals                                      | flow
// --------+----------------------------------------------+-------------------------------
// in      | in_valid, in_stall, func, direction,         | step/encoder pulses and ticks
//         | sense_millivolts                             |
// out     | out_valid, out_stall, phase, duty,           | one result per control tick
//         | position_error                               |
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data    | gain and current-limit writes
//
// one input transaction per cycle while in_stall is low; pulses give no result
// a control tick's result passes the queue, then the products, sum and output registers, before out_valid rises
// reset clears the error state, integrators and the queue; gains return to their defaults
// in_stall rises only when the two-entry queue to the multiply back end is full
// out_stall holds the output register and backs up the back end into the queue
module step_dir_servo_pid_current_limit_top
    import sdsp_pkg::*;
#(
    parameter int INTEGRAL_LIMIT = 4000,
    parameter int REDUCE_LIMIT   = 4094,
    parameter int STEP_SCALE     = 1
)(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              func,
    input  logic                    direction,
    input  logic [SENSE_W-1:0]      sense_millivolts,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    phase,
    output logic [DUTY_W-1:0]       duty,
    output logic signed [ERR_W-1:0] position_error,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              cfg_index,
    input  logic [GAIN_W-1:0]       cfg_data
);

    // signed width that holds +/- INTEGRAL_LIMIT
    localparam int INTEG_W = $clog2(INTEGRAL_LIMIT + 1) + 1;
    localparam int QW      = 2 * ERR_W + INTEG_W + RED_W;

    // configuration registers
    logic [GAIN_W-1:0] prop_gain_reg;
    logic [GAIN_W-1:0] integ_gain_reg;
    logic [GAIN_W-1:0] deriv_gain_reg;
    logic [GAIN_W-1:0] cur_limit_reg;
    gains_t            gains;

    // front to queue
    logic                      push;
    logic signed [ERR_W-1:0]   f_err, f_deriv;
    logic signed [INTEG_W-1:0] f_integ;
    logic [RED_W-1:0]          f_red;
    logic                      q_full, q_not_empty, q_pop;
    logic [QW-1:0]             q_in, q_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg  <= 8'd50;
            integ_gain_reg <= 8'd1;
            deriv_gain_reg <= 8'd0;
            cur_limit_reg  <= 8'd127;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_PROP_GAIN:  prop_gain_reg  <= cfg_data;
                CFG_INTEG_GAIN: integ_gain_reg <= cfg_data;
                CFG_DERIV_GAIN: deriv_gain_reg <= cfg_data;
                CFG_CUR_LIMIT:  cur_limit_reg  <= cfg_data;
                default:        prop_gain_reg  <= prop_gain_reg;
            endcase
        end
    end

    assign gains.prop  = prop_gain_reg;
    assign gains.integ = integ_gain_reg;
    assign gains.deriv = deriv_gain_reg;

    // only a full queue stalls the input
    assign in_stall = q_full;

    // front end: error counters, integral and current-limit integrator
    sdsp_front #(
        .INTEGRAL_LIMIT (INTEGRAL_LIMIT),
        .REDUCE_LIMIT   (REDUCE_LIMIT),
        .STEP_SCALE     (STEP_SCALE),
        .INTEG_W        (INTEG_W)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .q_full           (q_full),
        .func             (func),
        .direction        (direction),
        .sense_millivolts (sense_millivolts),
        .cur_setting      (cur_limit_reg),
        .push             (push),
        .tick_err         (f_err),
        .tick_deriv       (f_deriv),
        .tick_integ       (f_integ),
        .tick_red         (f_red)
    );

    assign q_in = {f_err, f_deriv, f_integ, f_red};

    // tick queue between front and back
    sdsp_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .pop_data  (q_out)
    );

    // back end: three gain multiplies, controller sum, duty shaping
    sdsp_back #(
        .INTEG_W (INTEG_W)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .gains          (gains),
        .q_not_empty    (q_not_empty),
        .q_err          (q_out[QW-1 -: ERR_W]),
        .q_deriv        (q_out[QW-ERR_W-1 -: ERR_W]),
        .q_integ        (q_out[RED_W +: INTEG_W]),
        .q_red          (q_out[RED_W-1:0]),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .phase          (phase),
        .duty           (duty),
        .position_error (position_error)
    );

endmodule

// ----- sim/tb_step_dir_servo_pid_current_limit_top.sv -----
`timescale 1ns / 1ps
module tb_step_dir_servo_pid_current_limit_top;
    import sdsp_pkg::*;

    // block parameters, kept at the defaults of the servo
    localparam int INTEGRAL_LIMIT = 4000;
    localparam int REDUCE_LIMIT   = 4094;
    localparam int STEP_SCALE     = 1;

    localparam int SENSE_MAX     = (1 << SENSE_W) - 1;
    localparam int SETTLE_CYCLES = 12;          // margin after the last owed result
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int RANDOM_ITEMS  = 1300;
    localparam int WRAP_ENC      = 200;         // far enough to push duty into the cap
    localparam int WRAP_STEP     = 400;         // carries the error through zero and below
    localparam int CLAMP_TICKS   = 24;          // enough ticks to pin the error integral

    // one expected motor drive result
    typedef struct {
        logic              phase;
        logic [DUTY_W-1:0] duty;
        logic [ERR_W-1:0]  err;
    } drive_t;

    // servo state, loop gains and the queue of duty results still owed by the block
    class duty_scoreboard;
        logic [ERR_W-1:0] err_count;
        logic [ERR_W-1:0] err_prev;
        int               err_integral;
        int               reduction;
        int               kp, ki, kd, limit_set;
        drive_t           expected_drive[$];
        int               errors, ticks, pulses, unused, checked;

        function new();
            kp = 50;
            ki = 1;
            kd = 0;
            limit_set = 127;
            err_count = '0;
            err_prev = '0;
            err_integral = 0;
            reduction = 0;
            errors = 0;
            ticks = 0;
            pulses = 0;
            unused = 0;
            checked = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [GAIN_W-1:0] v);
            case (idx)
                CFG_PROP_GAIN:  kp = v;
                CFG_INTEG_GAIN: ki = v;
                CFG_DERIV_GAIN: kd = v;
                CFG_CUR_LIMIT:  limit_set = v;
                default: ;
            endcase
        endfunction

        // one control tick: current integrator, error integral, pid sum, duty
        function drive_t predict_tick(logic [SENSE_W-1:0] mv);
            drive_t           res;
            logic [ERR_W-1:0] diff;
            int               e, deriv, acc, sum, mag, level;
            // threshold in millivolts is eight times the setting
            acc = reduction + int'(mv) - 8 * limit_set;
            if (acc > REDUCE_LIMIT)
                acc = REDUCE_LIMIT;
            else if (acc < 0)
                acc = 0;
            reduction = acc;
            e = $signed(err_count);
            diff = err_prev - err_count;
            deriv = $signed(diff);
            err_prev = err_count;
            acc = err_integral + e;
            if (acc > INTEGRAL_LIMIT)
                acc = INTEGRAL_LIMIT;
            else if (acc < -INTEGRAL_LIMIT)
                acc = -INTEGRAL_LIMIT;
            err_integral = acc;
            sum = kp * e + ki * err_integral - kd * deriv;
            res.phase = (sum >= 0);
            mag = (sum >= 0) ? sum : -sum;
            mag = mag >> MAG_SHIFT;
            if (mag > int'(DUTY_MAX))
                mag = int'(DUTY_MAX);
            level = mag - reduction;
            if (level < int'(DUTY_MIN))
                level = int'(DUTY_MIN);
            res.duty = DUTY_W'(level);
            res.err = err_count;
            return res;
        endfunction

        function void note_command(func_t f, logic dir, logic [SENSE_W-1:0] mv);
            case (f)
                FUNC_STEP: begin
                    if (dir)
                    begin
                        err_count = err_count + ERR_W'(STEP_SCALE);
                        err_prev = err_prev + ERR_W'(STEP_SCALE);
                    end
                    else
                    begin
                        err_count = err_count - ERR_W'(STEP_SCALE);
                        err_prev = err_prev - ERR_W'(STEP_SCALE);
                    end
                    pulses++;
                end
                FUNC_ENC: begin
                    err_count = dir ? err_count + 1'b1 : err_count - 1'b1;
                    pulses++;
                end
                FUNC_TICK: begin
                    expected_drive.push_back(predict_tick(mv));
                    ticks++;
                end
                default: unused++;
            endcase
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task check_drive(logic ph, logic [DUTY_W-1:0] d, logic [ERR_W-1:0] pe);
            drive_t want;
            if (expected_drive.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result phase %0b duty %0d error %0d",
                                          ph, d, $signed(pe)));
                return;
            end
            want = expected_drive.pop_front();
            checked++;
            if (ph !== want.phase)
                report_mismatch($sformatf("phase %0b, want %0b", ph, want.phase));
            if (d !== want.duty)
                report_mismatch($sformatf("duty %0d, want %0d", d, want.duty));
            if (pe !== want.err)
                report_mismatch($sformatf("position_error %0d, want %0d",
                                          $signed(pe), $signed(want.err)));
        endtask

        task flush_check();
            if (expected_drive.size() != 0)
                report_mismatch($sformatf("%0d duty results never arrived",
                                          expected_drive.size()));
        endtask
    endclass

    logic                    clk;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [1:0]              func = FUNC_UNUSED;
    logic                    direction = 1'b0;
    logic [SENSE_W-1:0]      sense_millivolts = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic                    phase;
    logic [DUTY_W-1:0]       duty;
    logic signed [ERR_W-1:0] position_error;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [1:0]              cfg_index = CFG_PROP_GAIN;
    logic [GAIN_W-1:0]       cfg_data = '0;

    duty_scoreboard board;
    int             burst_left = 0;
    int             settings_used = 0;
    int             cycles = 0;

    // receiver stall pattern state
    int             stall_mode = 0;
    int             mode_left = 0;
    int             hold_left = 0;
    logic           hold_val = 1'b0;

    step_dir_servo_pid_current_limit_top #(
        .INTEGRAL_LIMIT (INTEGRAL_LIMIT),
        .REDUCE_LIMIT   (REDUCE_LIMIT),
        .STEP_SCALE     (STEP_SCALE)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .func             (func),
        .direction        (direction),
        .sense_millivolts (sense_millivolts),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .phase            (phase),
        .duty             (duty),
        .position_error   (position_error),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver back-pressure: modes switch between free flow, light and heavy
    // random stalls, and long stall blocks that back the queue up into in_stall
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(50, 300);
        end
        else
            mode_left--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: begin
                if (hold_left == 0)
                begin
                    hold_val = ~hold_val;
                    hold_left = hold_val ? $urandom_range(5, 20) : $urandom_range(1, 6);
                end
                hold_left--;
                out_stall <= hold_val;
            end
        endcase
    end

    // result monitor: a transaction completes when out_valid is high and out_stall low
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_drive(phase, duty, position_error);
    end

    // sender pacing: bursts of random length, random gaps between them,
    // and a share of zero-length gaps so back-to-back stretches occur
    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        burst_left--;
    endtask

    // present one input transaction and hold it until the block takes it
    task automatic send_item(func_t f, logic dir, logic [SENSE_W-1:0] mv);
        pace_sender();
        in_valid <= 1'b1;
        func <= f;
        direction <= dir;
        sense_millivolts <= mv;
        do @(posedge clk); while (in_stall);
        board.note_command(f, dir, mv);
    endtask

    // stop sending, wait for every owed result, then let trailing pulses settle
    task automatic drain();
        in_valid <= 1'b0;
        while (board.expected_drive.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [GAIN_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        board.set_reg(idx, v);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // only called with the block idle
    task automatic configure(logic [GAIN_W-1:0] p, logic [GAIN_W-1:0] i,
                             logic [GAIN_W-1:0] d, logic [GAIN_W-1:0] lim);
        write_reg(CFG_PROP_GAIN, p);
        write_reg(CFG_INTEG_GAIN, i);
        write_reg(CFG_DERIV_GAIN, d);
        write_reg(CFG_CUR_LIMIT, lim);
        settings_used++;
    endtask

    // sense samples: rails, full range, and a cluster around the current
    // threshold so the reduction integrator moves both ways without pinning
    function automatic logic [SENSE_W-1:0] pick_sense();
        int v;
        case ($urandom_range(0, 9))
            0: v = 0;
            1: v = SENSE_MAX;
            2, 3: v = $urandom_range(0, SENSE_MAX);
            default: v = 8 * board.limit_set + int'($urandom_range(0, 96)) - 48;
        endcase
        if (v < 0)
            v = 0;
        else if (v > SENSE_MAX)
            v = SENSE_MAX;
        return SENSE_W'(v);
    endfunction

    task automatic run_directed();
        // zero error, zero sense: sum of zero gives phase 1 and the duty floor
        send_item(FUNC_TICK, 1'b0, '0);
        // direction is ignored on a tick; full-scale sense drives the reduction up
        send_item(FUNC_TICK, 1'b1, SENSE_W'(SENSE_MAX));
        // sense is ignored on pulses
        send_item(FUNC_STEP, 1'b1, SENSE_W'(SENSE_MAX));
        send_item(FUNC_STEP, 1'b0, '0);
        // error goes below zero and wraps as unsigned
        send_item(FUNC_STEP, 1'b0, '1);
        send_item(FUNC_ENC, 1'b1, '0);
        send_item(FUNC_ENC, 1'b0, '1);
        send_item(FUNC_ENC, 1'b0, '0);
        // unused function code must change nothing and give no result
        send_item(FUNC_UNUSED, 1'b1, '1);
        send_item(FUNC_UNUSED, 1'b0, '0);
        // sense exactly at the default threshold
        send_item(FUNC_TICK, 1'b0, SENSE_W'(8 * 127));
        repeat (4) send_item(FUNC_ENC, 1'b1, '0);
        send_item(FUNC_TICK, 1'b1, '0);
        send_item(FUNC_STEP, 1'b1, '0);
        send_item(FUNC_TICK, 1'b0, '0);
        drain();
        // all gains at max, zero current threshold: reduction saturates, duty floors
        configure(8'd255, 8'd255, 8'd255, 8'd0);
        send_item(FUNC_TICK, 1'b0, SENSE_W'(SENSE_MAX));
        send_item(FUNC_TICK, 1'b0, SENSE_W'(SENSE_MAX));
        send_item(FUNC_ENC, 1'b0, '0);
        send_item(FUNC_TICK, 1'b0, '0);
        drain();
        // max threshold with zero sense pulls the reduction back to zero
        configure(8'd255, 8'd0, 8'd255, 8'd255);
        send_item(FUNC_TICK, 1'b0, '0);
        send_item(FUNC_TICK, 1'b0, '0);
        send_item(FUNC_STEP, 1'b0, '0);
        send_item(FUNC_TICK, 1'b1, '0);
        drain();
    endtask

    // long pulse runs at full gains: encoder pulses push duty into the cap and
    // give a large derivative, repeated ticks pin the error integral high, step
    // pulses carry error and previous error down through zero, and further
    // ticks pin the integral low
    task automatic run_wrap();
        configure(8'd255, 8'd255, 8'd255, 8'd255);
        send_item(FUNC_TICK, 1'b0, pick_sense());
        repeat (WRAP_ENC) send_item(FUNC_ENC, 1'b1, pick_sense());
        repeat (CLAMP_TICKS) send_item(FUNC_TICK, 1'b0, pick_sense());
        send_item(FUNC_TICK, 1'b1, pick_sense());
        for (int n = 1; n <= WRAP_STEP; n++)
        begin
            send_item(FUNC_STEP, 1'b0, pick_sense());
            if (n % 50 == 0)
                send_item(FUNC_TICK, 1'b0, pick_sense());
        end
        repeat (2 * CLAMP_TICKS) send_item(FUNC_TICK, 1'b0, pick_sense());
        drain();
    endtask

    // random mix; direction bias shifts every 50 items so the error drifts
    task automatic run_random(int count);
        int    done, pick, up_pct;
        func_t f;
        done = 0;
        up_pct = 50;
        while (done < count)
        begin
            if (done % 50 == 0)
                up_pct = $urandom_range(20, 80);
            pick = $urandom_range(0, 99);
            if (pick < 30)
                f = FUNC_TICK;
            else if (pick < 55)
                f = FUNC_STEP;
            else if (pick < 97)
                f = FUNC_ENC;
            else
                f = FUNC_UNUSED;
            send_item(f, $urandom_range(0, 99) < up_pct, pick_sense());
            if (f != FUNC_UNUSED)
                done++;
        end
    endtask

    initial
    begin
        board = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_wrap();

        // random phases over extreme, default and random register settings
        configure(8'd0, 8'd0, 8'd0, 8'd0);
        run_random(RANDOM_ITEMS / 6);
        drain();
        configure(8'd255, 8'd255, 8'd255, 8'd255);
        run_random(RANDOM_ITEMS / 6);
        drain();
        configure(8'd50, 8'd1, 8'd0, 8'd127);
        run_random(RANDOM_ITEMS / 6);
        drain();
        repeat (3)
        begin
            configure(GAIN_W'($urandom_range(0, 255)), GAIN_W'($urandom_range(0, 255)),
                      GAIN_W'($urandom_range(0, 255)), GAIN_W'($urandom_range(0, 255)));
            run_random(RANDOM_ITEMS / 6);
            drain();
        end

        board.flush_check();
        $display("run covered %0d control ticks, %0d step/encoder pulses, %0d unused codes",
                 board.ticks, board.pulses, board.unused);
        $display("%0d duty results checked over %0d register settings, %0d mismatches",
                 board.checked, settings_used, board.errors);
        if (board.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- step_dir_servo_pid_current_limit_top.f -----
rtl/core/sdsp_pkg.sv
rtl/core/sdsp_front.sv
rtl/core/sdsp_queue.sv
rtl/core/sdsp_back.sv
rtl/core/step_dir_servo_pid_current_limit_top.sv
sim/tb_step_dir_servo_pid_current_limit_top.sv
